/* hw/rtl/sha256_pkg.sv */
`default_nettype none
package sha256_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned QueueDepth = 4;

  // One queue entry: a classified input word.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } core_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_front.sv */
`default_nettype none
module sha256_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  has_byte,
  input  wire logic                  last_byte,
  input  wire logic                  valid,
  output logic                       ready,
  output sha256_pkg::sha_item_t      q_item,
  output logic                       q_valid,
  input  wire logic                  q_ready
);
  import sha256_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  sha_item_t          mem [QueueDepth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [PtrW:0]      count;
  logic               push;
  logic               pop;

  // Words with neither a byte nor an end mark are dropped here.
  assign ready   = (count != (PtrW+1)'(QueueDepth));
  assign push    = valid && ready && (has_byte || last_byte);
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_ready;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: data_byte, has: has_byte, last: last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == (PtrW+1)'(QueueDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

/* hw/rtl/sha256_back.sv */
`default_nettype none
module sha256_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  sha256_pkg::sha_item_t      q_item,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  output logic [31:0]                digest_word,
  output logic [2:0]                 word_index,
  output logic                       last_word,
  output logic                       out_valid,
  input  wire logic                  out_ready
);
  import sha256_pkg::*;

  core_state_t  state;
  core_state_t  state_next;

  logic [31:0]  hw [8];
  logic [31:0]  wv [8];
  logic [31:0]  blk [16];
  logic [63:0]  byte_count;
  logic [6:0]   round_index;
  logic         pend_last;     // finish the message after this block
  logic         pad_stage;     // 0: first pad pass, 1: length-only block
  logic         finishing;     // current block is the final one
  logic [2:0]   out_idx;

  logic [5:0]   pos;
  logic [3:0]   t;
  logic [31:0]  w15;
  logic [31:0]  w2;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  ch;
  logic [31:0]  mj;
  logic         take;
  logic         byte_fills;

  assign pos        = byte_count[5:0];
  assign take       = q_valid && q_ready;
  assign byte_fills = q_item.has && (pos == 6'd63);
  assign t          = round_index[3:0];
  assign w15        = blk[t + 4'd1];
  assign w2         = blk[t + 4'd14];
  assign s0         = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
  assign s1         = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
  assign w_new      = blk[t] + s0 + blk[t + 4'd9] + s1;
  assign w_cur      = (round_index >= 7'd16) ? w_new : blk[t];
  assign ch         = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign mj         = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1         = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
                      + ch + round_k(round_index[5:0]) + w_cur;
  assign t2         = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22)) + mj;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (byte_fills) state_next = ST_ROUND;
          else if (q_item.last) state_next = ST_PAD;
        end
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (round_index == 7'(RoundCount - 1)) state_next = ST_ADD;
      ST_ADD: begin
        if (finishing) state_next = ST_OUT;
        else if (pend_last) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT:   if (out_ready && out_idx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready     = (state == ST_IDLE);
    out_valid   = (state == ST_OUT);
    digest_word = hw[out_idx];
    word_index  = out_idx;
    last_word   = (out_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      round_index <= '0;
      pend_last   <= 1'b0;
      pad_stage   <= 1'b0;
      finishing   <= 1'b0;
      out_idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          round_index <= '0;
          pad_stage   <= 1'b0;
          finishing   <= 1'b0;
          if (take) begin
            if (q_item.has) byte_count <= byte_count + 64'd1;
            pend_last <= q_item.last;
          end
        end
        ST_PAD: begin
          round_index <= '0;
          // Length fits unless the first pad pass starts at byte 56 or later.
          finishing   <= pad_stage || (pos < 6'd56);
          pad_stage   <= 1'b1;
        end
        ST_ROUND: round_index <= round_index + 7'd1;
        ST_ADD: begin
          round_index <= '0;
          if (finishing) begin
            pend_last <= 1'b0;
            out_idx   <= '0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) byte_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
    end else begin
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + wv[i];
      end else if (state == ST_OUT && out_ready && out_idx == 3'd7) begin
        for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take && q_item.has) begin
      blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= q_item.data;
    end else if (state == ST_PAD) begin
      for (int b = 0; b < 64; b++) begin
        if (pad_stage || b > int'(pos)) blk[b / 4][(3 - (b % 4)) * 8 +: 8] <= 8'h00;
        else if (b == int'(pos)) blk[b / 4][(3 - (b % 4)) * 8 +: 8] <= 8'h80;
      end
      if (pad_stage || pos < 6'd56) begin
        blk[14] <= byte_count[60:29];
        blk[15] <= {byte_count[28:0], 3'b000};
      end
    end else if (state == ST_ROUND && round_index >= 7'd16) begin
      blk[t] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state_next == ST_ROUND && state != ST_ROUND) begin
      for (int i = 0; i < 8; i++) wv[i] <= hw[i];
    end else if (state == ST_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> round_index < 7'(RoundCount)) else $error("round overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_idx)) else $error("output dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> state == ST_IDLE) else $error("take while busy");

endmodule
`default_nettype wire

/* hw/rtl/sha256_hasher_core.sv */
`default_nettype none
// A word is registered in the queue before the back can take it. A byte that completes a block
// then holds the back for 64 rounds and one add. A last word costs, per block compressed (one or
// two, after any block its own byte completes), one pad step, 64 rounds and one add, and then
// the eight digest words follow at one per accepted cycle.
// The back takes one byte per cycle while idle inside a block and takes none while it compresses
// a 64-byte block in the single shared round unit, which does one round per cycle.
// Reset (rst, synchronous, active high) restores the initial hash and empties the queue.
module sha256_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last_byte,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import sha256_pkg::*;

  // The front takes each word into a short queue, dropping empty ones,
  // so the source can keep moving, until the queue is full, while the back compresses a block.
  sha_item_t  q_item;
  logic       q_valid;
  logic       q_ready;

  sha256_front u_front (
    .clk, .rst, .data_byte, .has_byte, .last_byte,
    .valid(in_valid), .ready(in_ready),
    .q_item, .q_valid, .q_ready
  );

  // The back packs bytes, pads, runs the rounds and presents the digest.
  sha256_back u_back (
    .clk, .rst, .q_item, .q_valid, .q_ready,
    .digest_word, .word_index, .last_word, .out_valid, .out_ready
  );

endmodule
`default_nettype wire
